/* rtl/ant_pkg.sv */
// ant_pkg: shared types, sizes and codes of the aging neighbor table.
// No dependencies; every other file of the block imports it.
package ant_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ID_W        = 16;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned AGE_W       = 16;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned FCNT_W      = 6;

  localparam logic [AGE_W-1:0] PRUNE_RESET = 16'd150;
  localparam logic [AGE_W-1:0] FRESH_RESET = 16'd100;

  // register index, taken from paddr[2]
  localparam logic REG_PRUNE = 1'b0;
  localparam logic REG_FRESH = 1'b1;

  // input command codes
  localparam logic CMD_HEARD  = 1'b0;
  localparam logic CMD_BEACON = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_LIST = 2'd1,
    KIND_END  = 2'd2
  } ant_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEARD,
    ST_PRUNE
  } ant_state_e;

  typedef enum logic [1:0] {
    CHAIN_HOLD,
    CHAIN_SHIFT_DN,
    CHAIN_REFRESH,
    CHAIN_POP
  } ant_op_e;

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
  } ant_entry_t;

  typedef struct packed {
    ant_op_e          op;
    logic             push;
    logic [IDX_W-1:0] push_idx;
  } ant_ctrl_t;

endpackage

/* rtl/aging_neighbor_table.sv */
// aging_neighbor_table: top level with control sequencer, result register
// and APB register file. Depends on ant_pkg and ant_chain (row of ant_cell).
//
// The table is a row of TABLE_DEPTH cells, newest insertion in cell 0. Valid
// entries always fill cells 0..n-1. A heard beat is registered at accept
// and answered from ST_HEARD once the result slot is free: all cells
// compare the id at once; a hit refreshes the stamp, a miss shifts the row
// down one cell and writes cell 0, and a full table drops the id with
// dropped_full set. A beacon beat runs the prune pass over its n live entries
// (at most 32 at the default depth): every
// cycle the head cell is popped, its age (now_ms - stamp, modulo 2^32) is
// checked, a survivor is written back at the tail of the live region and, if
// it is also younger than fresh_age_ms, goes out as a listed beat. After n
// pops the survivors are back in their order in cells 0..keep-1 and an end
// beat with the count closes the list. The pass pauses while a result beat
// is stalled. The input is stalled while a beat is being worked on. Registers
// on APB: prune_age_ms at 0x0 (reset 150), fresh_age_ms at 0x4 (reset 100);
// pready is always high, reads return the value zero-extended.
module aging_neighbor_table import ant_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [ID_W-1:0]    neighbor_id_i,
  input  logic [STAMP_W-1:0] now_ms_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [ID_W-1:0]    listed_id_o,
  output logic               was_new_o,
  output logic               dropped_full_o,
  output logic [FCNT_W-1:0]  fresh_count_o,
  output logic               last_o,
  // APB
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  ant_state_e         state_q, state_d;
  logic               cmd_q;
  logic [ID_W-1:0]    id_q;
  logic [STAMP_W-1:0] now_q;
  logic [CNT_W-1:0]   count_q, count_d;    // live entries
  logic [CNT_W-1:0]   pop_cnt_q, pop_cnt_d;
  logic [CNT_W-1:0]   listed_q, listed_d;
  logic [AGE_W-1:0]   prune_q, fresh_q;

  // result register
  logic               out_valid_q;
  ant_kind_e          out_kind_q, out_kind_d;
  logic [ID_W-1:0]    out_id_q, out_id_d;
  logic               out_new_q, out_new_d;
  logic               out_drop_q, out_drop_d;
  logic [FCNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic               out_last_q, out_last_d;
  logic               out_load;

  ant_ctrl_t          ctrl;
  ant_entry_t         head;
  logic               hit;
  logic [ID_W-1:0]    key_id;
  logic [STAMP_W-1:0] key_stamp;
  logic [STAMP_W-1:0] age;
  logic               survive, fresh;
  logic               slot_free, in_accept, full;
  logic [CNT_W-1:0]   cnt_m1;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(TABLE_DEPTH));
  assign cnt_m1     = count_q - CNT_W'(1);

  assign age     = now_q - head.stamp;
  assign survive = age < {{(STAMP_W-AGE_W){1'b0}}, prune_q};
  assign fresh   = age < {{(STAMP_W-AGE_W){1'b0}}, fresh_q};

  // heard compares the incoming id; a pop writes the head back at the tail
  assign key_id    = (state_q == ST_PRUNE) ? head.id    : id_q;
  assign key_stamp = (state_q == ST_PRUNE) ? head.stamp : now_q;

  ant_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .key_id_i    (key_id),
    .key_stamp_i (key_stamp),
    .head_o      (head),
    .hit_o       (hit)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (cmd_i == CMD_BEACON) ? ST_PRUNE : ST_HEARD;
        end
      end
      ST_HEARD: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_PRUNE: begin
        if (slot_free && (pop_cnt_q == '0)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctrl       = '{op: CHAIN_HOLD, push: 1'b0, push_idx: cnt_m1[IDX_W-1:0]};
    count_d    = count_q;
    pop_cnt_d  = pop_cnt_q;
    listed_d   = listed_q;
    out_load   = 1'b0;
    out_kind_d = KIND_ACK;
    out_id_d   = '0;
    out_new_d  = 1'b0;
    out_drop_d = 1'b0;
    out_cnt_d  = '0;
    out_last_d = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          pop_cnt_d = count_q;
          listed_d  = '0;
        end
      end
      ST_HEARD: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (hit) begin
            ctrl.op = CHAIN_REFRESH;
          end else if (full) begin
            out_drop_d = 1'b1;
          end else begin
            ctrl.op   = CHAIN_SHIFT_DN;
            count_d   = count_q + CNT_W'(1);
            out_new_d = 1'b1;
          end
        end
      end
      ST_PRUNE: begin
        if (slot_free) begin
          if (pop_cnt_q == '0) begin
            out_load   = 1'b1;
            out_kind_d = KIND_END;
            out_cnt_d  = FCNT_W'(listed_q);
          end else begin
            ctrl.op   = CHAIN_POP;
            ctrl.push = survive;
            pop_cnt_d = pop_cnt_q - CNT_W'(1);
            if (!survive) begin
              count_d = cnt_m1;
            end
            if (survive && fresh) begin
              out_load   = 1'b1;
              out_kind_d = KIND_LIST;
              out_id_d   = head.id;
              out_last_d = 1'b0;
              listed_d   = listed_q + CNT_W'(1);
            end
          end
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pop_cnt_q   <= '0;
      listed_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pop_cnt_q <= pop_cnt_d;
      listed_q  <= listed_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= cmd_i;
      id_q  <= neighbor_id_i;
      now_q <= now_ms_i;
    end
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_id_q   <= out_id_d;
      out_new_q  <= out_new_d;
      out_drop_q <= out_drop_d;
      out_cnt_q  <= out_cnt_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign listed_id_o    = out_id_q;
  assign was_new_o      = out_new_q;
  assign dropped_full_o = out_drop_q;
  assign fresh_count_o  = out_cnt_q;
  assign last_o         = out_last_q;

  // APB register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prune_q <= PRUNE_RESET;
      fresh_q <= FRESH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_FRESH) begin
        fresh_q <= pwdata[AGE_W-1:0];
      end else begin
        prune_q <= pwdata[AGE_W-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PRUNE) ? {{(DATA_W-AGE_W){1'b0}}, prune_q}
                                          : {{(DATA_W-AGE_W){1'b0}}, fresh_q};

  // checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("live entry count beyond table depth");

  a_pop_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRUNE) |-> (pop_cnt_q <= count_q))
    else $error("prune pass pops more entries than are live");

  a_heard_ack : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HEARD && slot_free) |=>
      (out_valid_q && out_kind_q == KIND_ACK && out_last_q && state_q == ST_IDLE))
    else $error("heard beat did not give a final ack");

  a_beacon_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRUNE && slot_free && pop_cnt_q == '0 && cmd_q) |=>
      (out_valid_q && out_kind_q == KIND_END && out_last_q && state_q == ST_IDLE))
    else $error("beacon list not closed by end beat");

endmodule

/* rtl/ant_cell.sv */
// ant_cell: one table slot (valid, id, stamp) with its neighbor moves.
// Depends on ant_pkg.
module ant_cell import ant_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ant_ctrl_t          ctrl_i,
  input  logic [IDX_W-1:0]   idx_i,
  input  logic [ID_W-1:0]    key_id_i,
  input  logic [STAMP_W-1:0] key_stamp_i,
  input  ant_entry_t         prev_i,
  input  ant_entry_t         next_i,
  output ant_entry_t         ent_o,
  output logic               hit_o
);

  logic               valid_q, valid_d;
  logic [ID_W-1:0]    id_q, id_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;

  assign hit_o = valid_q && (id_q == key_id_i);
  assign ent_o = '{valid: valid_q, id: id_q, stamp: stamp_q};

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    stamp_d = stamp_q;
    case (ctrl_i.op)
      CHAIN_SHIFT_DN: begin
        valid_d = prev_i.valid;
        id_d    = prev_i.id;
        stamp_d = prev_i.stamp;
      end
      CHAIN_REFRESH: begin
        if (hit_o) begin
          stamp_d = key_stamp_i;
        end
      end
      CHAIN_POP: begin
        // survivor re-enters at the tail of the live region
        if (ctrl_i.push && (idx_i == ctrl_i.push_idx)) begin
          valid_d = 1'b1;
          id_d    = key_id_i;
          stamp_d = key_stamp_i;
        end else begin
          valid_d = next_i.valid;
          id_d    = next_i.id;
          stamp_d = next_i.stamp;
        end
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    stamp_q <= stamp_d;
  end

endmodule

/* rtl/ant_chain.sv */
// ant_chain: row of ant_cell slots, newest entry in slot 0, plus hit reduction.
// Depends on ant_pkg and ant_cell.
module ant_chain import ant_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ant_ctrl_t          ctrl_i,
  input  logic [ID_W-1:0]    key_id_i,
  input  logic [STAMP_W-1:0] key_stamp_i,
  output ant_entry_t         head_o,
  output logic               hit_o
);

  ant_entry_t                 ent   [TABLE_DEPTH];
  ant_entry_t                 prv   [TABLE_DEPTH];
  ant_entry_t                 nxt   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]     hit_vec;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prv[i] = '{valid: 1'b1, id: key_id_i, stamp: key_stamp_i};
    end else begin : g_mid
      assign prv[i] = ent[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign nxt[i] = '0;
    end else begin : g_body
      assign nxt[i] = ent[i+1];
    end

    ant_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_i),
      .idx_i       (IDX_W'(i)),
      .key_id_i    (key_id_i),
      .key_stamp_i (key_stamp_i),
      .prev_i      (prv[i]),
      .next_i      (nxt[i]),
      .ent_o       (ent[i]),
      .hit_o       (hit_vec[i])
    );
  end

  assign head_o = ent[0];
  assign hit_o  = |hit_vec;

endmodule
